@@ rtl/core/assert_macros.svh @@
// assertion helpers included by iesm_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/iesm_pkg.sv @@
// ----------------------------------------------------------------------------
// iesm_pkg
// types and codes shared by the interrupt event slot manager
// ----------------------------------------------------------------------------
package iesm_pkg;

    localparam int unsigned SLOT_MAX = 32;
    localparam int unsigned SLOT_ID_W = 5;

    // request opcodes as seen on the port
    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE     = 3'd1,
        OP_SUBMIT   = 3'd2,
        OP_COMPLETE = 3'd3,
        OP_IRQ      = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NONE_FREE   = 3'd1,
        ST_BAD_ID      = 3'd2,
        ST_NOT_ALLOC   = 3'd3,
        ST_ALREADY_SUB = 3'd4,
        ST_NOT_SUB     = 3'd5
    } status_t;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ALLOC,
        CMD_FREE,
        CMD_SUBMIT,
        CMD_COMPLETE,
        CMD_IRQ,
        CMD_BAD_ID
    } cmd_t;

    typedef struct packed {
        cmd_t                  kind;
        logic                  release_on_done;
        logic [SLOT_ID_W-1:0]  id;
        logic [SLOT_MAX-1:0]   mask;
    } req_t;

endpackage

@@ rtl/core/iesm_front.sv @@
// ----------------------------------------------------------------------------
// iesm_front
// decodes a request and checks its slot id against the table size
// ----------------------------------------------------------------------------
module iesm_front #(
    parameter int unsigned NUM_SLOTS = 32
) (
    input  logic [2:0]      op,
    input  logic            release_on_done,
    input  logic [7:0]      slot_id,
    input  logic [31:0]     irq_mask,
    output iesm_pkg::req_t  req
);
    import iesm_pkg::*;

    localparam logic [SLOT_MAX-1:0] SLOT_MASK = {SLOT_MAX{1'b1}} >> (SLOT_MAX - NUM_SLOTS);

    logic id_bad;

    assign id_bad = (slot_id >= 8'(NUM_SLOTS));

    always_comb
    begin
        req.release_on_done = release_on_done;
        req.id              = slot_id[SLOT_ID_W-1:0];
        // mask bits above the table are dropped here
        req.mask            = irq_mask & SLOT_MASK;
        case (op_t'(op))
            OP_ALLOC:    req.kind = CMD_ALLOC;
            OP_FREE:     req.kind = id_bad ? CMD_BAD_ID : CMD_FREE;
            OP_SUBMIT:   req.kind = id_bad ? CMD_BAD_ID : CMD_SUBMIT;
            OP_COMPLETE: req.kind = id_bad ? CMD_BAD_ID : CMD_COMPLETE;
            OP_IRQ:      req.kind = CMD_IRQ;
            default:     req.kind = CMD_NOP;
        endcase
    end

endmodule

@@ rtl/core/iesm_queue.sv @@
// ----------------------------------------------------------------------------
// iesm_queue
// two-entry fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module iesm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iesm_pkg::req_t  push_req,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output iesm_pkg::req_t  pop_req
);
    import iesm_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_req = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ rtl/core/iesm_back.sv @@
// ----------------------------------------------------------------------------
// iesm_back
// holds the slot flags, executes one request a cycle while exec is high and registers its result
// ----------------------------------------------------------------------------
module iesm_back #(
    parameter int unsigned NUM_SLOTS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            exec,
    input  iesm_pkg::req_t  req,
    output logic            result_valid,
    output logic [2:0]      status,
    output logic [4:0]      granted_id,
    output logic [31:0]     done_mask,
    output logic [31:0]     fail_mask
);
    import iesm_pkg::*;

    `include "assert_macros.svh"

    localparam logic [SLOT_MAX-1:0] SLOT_MASK = {SLOT_MAX{1'b1}} >> (SLOT_MAX - NUM_SLOTS);

    logic [SLOT_MAX-1:0]  alloc_reg, alloc_next;
    logic [SLOT_MAX-1:0]  sub_reg, sub_next;
    logic [SLOT_MAX-1:0]  rel_reg, rel_next;
    logic                 valid_reg;
    status_t              status_reg, status_next;
    logic [SLOT_ID_W-1:0] grant_reg, grant_next;
    logic [SLOT_MAX-1:0]  done_reg, done_next;
    logic [SLOT_MAX-1:0]  fail_reg, fail_next;

    logic [SLOT_MAX-1:0]  free_vec;
    logic [SLOT_MAX-1:0]  free_first;
    logic [SLOT_ID_W-1:0] free_idx;
    logic [SLOT_MAX-1:0]  id_hot;
    logic [SLOT_MAX-1:0]  irq_hit;

    // lowest free slot, isolated then encoded
    assign free_vec   = ~alloc_reg & SLOT_MASK;
    assign free_first = free_vec & (~free_vec + SLOT_MAX'(1));

    always_comb
    begin
        free_idx = '0;
        for (int i = 0; i < SLOT_MAX; i++)
        begin
            if (free_first[i])
            begin
                free_idx = free_idx | SLOT_ID_W'(i);
            end
        end
    end

    assign id_hot  = SLOT_MAX'(1) << req.id;
    assign irq_hit = req.mask & alloc_reg & sub_reg;

    always_comb
    begin
        alloc_next  = alloc_reg;
        sub_next    = sub_reg;
        rel_next    = rel_reg;
        status_next = ST_OK;
        grant_next  = '0;
        done_next   = '0;
        fail_next   = '0;
        case (req.kind)
            CMD_ALLOC:
            begin
                if (free_vec == '0)
                begin
                    status_next = ST_NONE_FREE;
                end
                else
                begin
                    grant_next = free_idx;
                    alloc_next = alloc_reg | free_first;
                    rel_next   = req.release_on_done ? (rel_reg | free_first)
                                                     : (rel_reg & ~free_first);
                end
            end
            CMD_FREE:
            begin
                if ((alloc_reg & id_hot) == '0)
                begin
                    status_next = ST_NOT_ALLOC;
                end
                else
                begin
                    alloc_next = alloc_reg & ~id_hot;
                    sub_next   = sub_reg & ~id_hot;
                    rel_next   = rel_reg & ~id_hot;
                end
            end
            CMD_SUBMIT:
            begin
                if ((alloc_reg & id_hot) == '0)
                begin
                    status_next = ST_NOT_ALLOC;
                end
                else if ((sub_reg & id_hot) != '0)
                begin
                    status_next = ST_ALREADY_SUB;
                end
                else
                begin
                    sub_next = sub_reg | id_hot;
                end
            end
            CMD_COMPLETE:
            begin
                if ((alloc_reg & id_hot) == '0)
                begin
                    status_next = ST_NOT_ALLOC;
                end
                else if ((sub_reg & id_hot) == '0)
                begin
                    status_next = ST_NOT_SUB;
                end
                else
                begin
                    done_next  = id_hot;
                    alloc_next = alloc_reg & ~(id_hot & rel_reg);
                    sub_next   = sub_reg & ~id_hot;
                    rel_next   = rel_reg & ~id_hot;
                end
            end
            CMD_IRQ:
            begin
                done_next  = irq_hit;
                fail_next  = req.mask & ~irq_hit;
                alloc_next = alloc_reg & ~(irq_hit & rel_reg);
                sub_next   = sub_reg & ~irq_hit;
                rel_next   = rel_reg & ~irq_hit;
            end
            CMD_BAD_ID:
            begin
                status_next = ST_BAD_ID;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= '0;
            sub_reg   <= '0;
            rel_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= exec;
            if (exec)
            begin
                alloc_reg <= alloc_next;
                sub_reg   <= sub_next;
                rel_reg   <= rel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg <= status_next;
            grant_reg  <= grant_next;
            done_reg   <= done_next;
            fail_reg   <= fail_next;
        end
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign granted_id   = grant_reg;
    assign done_mask    = done_reg;
    assign fail_mask    = fail_reg;

    `ASSERT_ALWAYS(a_sub_needs_alloc, clk, rst_n, (sub_reg & ~alloc_reg) == '0,
        "slot in flight without being allocated")
    `ASSERT_ALWAYS(a_no_flags_past_table, clk, rst_n,
        ((alloc_reg | sub_reg | rel_reg) & ~SLOT_MASK) == '0,
        "flag set on a slot past the table")
    `ASSERT_IMPLIES(a_done_fail_disjoint, clk, rst_n, valid_reg,
        (done_reg & fail_reg) == '0, "slot both completed and failed")
    `ASSERT_NEXT(a_alloc_grants_slot, clk, rst_n,
        exec && req.kind == CMD_ALLOC && free_vec != '0,
        alloc_reg[grant_reg] && !sub_reg[grant_reg], "granted slot not allocated")

endmodule

@@ rtl/core/interrupt_event_slot_manager_top.sv @@
// ----------------------------------------------------------------------------
// interrupt_event_slot_manager_top
// event slot table with alloc, free, submit, complete and interrupt mask
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// request   in         start high, busy low   op, release_on_done, slot_id, irq_mask
// result    out        result_valid pulse     status, granted_id, done_mask, fail_mask
//
// one transaction in gives exactly one transaction out, in order
// a request is queued at the accepting edge and executed the next cycle;
// its result shows on the ports the cycle after that
// the back end executes one request per cycle, so a request can be taken
// every cycle; busy only rises when the two-entry queue is full
// reset clears every slot flag at once; no sweep is needed
// the receiver cannot stall: each result is shown for exactly one cycle
//
module interrupt_event_slot_manager_top #(
    parameter int unsigned NUM_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic        release_on_done,
    input  logic [7:0]  slot_id,
    input  logic [31:0] irq_mask,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [4:0]  granted_id,
    output logic [31:0] done_mask,
    output logic [31:0] fail_mask
);
    import iesm_pkg::*;

    req_t front_req;
    req_t back_req;
    logic q_full;
    logic q_empty;
    logic push;
    logic exec;

    // a transaction is taken whenever the queue has room
    assign busy = q_full;
    assign push = start && !q_full;
    // the back end never stalls, so it drains the queue every cycle
    assign exec = !q_empty;

    // front: decode the opcode and range-check the slot id
    iesm_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .op              (op),
        .release_on_done (release_on_done),
        .slot_id         (slot_id),
        .irq_mask        (irq_mask),
        .req             (front_req)
    );

    // queue between the classifier and the executor
    iesm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (front_req),
        .full     (q_full),
        .pop      (exec),
        .empty    (q_empty),
        .pop_req  (back_req)
    );

    // back: slot flag table and registered result
    iesm_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .exec         (exec),
        .req          (back_req),
        .result_valid (result_valid),
        .status       (status),
        .granted_id   (granted_id),
        .done_mask    (done_mask),
        .fail_mask    (fail_mask)
    );

endmodule
